// ===== sv/pdf417tc_pkg.sv =====
// Shared types, codeword constants and character tables of the PDF417 text decoder.
package pdf417tc_pkg;

  localparam int CW_W     = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int VAL_W    = 5;

  // control codewords
  localparam logic [CW_W-1:0] CW_FIRST_CTRL  = 10'd900;
  localparam logic [CW_W-1:0] CW_TEXT_LATCH  = 10'd900;
  localparam logic [CW_W-1:0] CW_BYTE_LATCH  = 10'd901;
  localparam logic [CW_W-1:0] CW_NUM_LATCH   = 10'd902;
  localparam logic [CW_W-1:0] CW_BYTE_SHIFT  = 10'd913;
  localparam logic [CW_W-1:0] CW_MACRO_CTRL  = 10'd922;
  localparam logic [CW_W-1:0] CW_MACRO_OPT   = 10'd923;
  localparam logic [CW_W-1:0] CW_BYTE_LATCH6 = 10'd924;
  localparam logic [CW_W-1:0] CW_ECI_USER    = 10'd925;
  localparam logic [CW_W-1:0] CW_ECI_GP      = 10'd926;
  localparam logic [CW_W-1:0] CW_ECI_CHARSET = 10'd927;
  localparam logic [CW_W-1:0] CW_MACRO_BEGIN = 10'd928;

  // floor(cw / 30) = (cw * DIV30_MUL) >> DIV30_SHIFT, exact for cw below 1489
  localparam int DIV30_MUL   = 1093;
  localparam int DIV30_SHIFT = 15;
  localparam int PROD_W      = 21;

  // base-30 value codes
  localparam logic [VAL_W-1:0] VAL_LETTERS  = 5'd26; // first non-letter value
  localparam logic [VAL_W-1:0] VAL_SPACE    = 5'd26;
  localparam logic [VAL_W-1:0] VAL_LL_AS    = 5'd27; // lower latch or alpha shift
  localparam logic [VAL_W-1:0] VAL_ML       = 5'd28; // mixed latch
  localparam logic [VAL_W-1:0] VAL_PS       = 5'd29; // punct shift / alpha latch
  localparam logic [VAL_W-1:0] VAL_MIX_CHRS = 5'd25; // mixed table size
  localparam logic [VAL_W-1:0] VAL_MIX_PL   = 5'd25;
  localparam logic [VAL_W-1:0] VAL_MIX_SP   = 5'd26;
  localparam logic [VAL_W-1:0] VAL_MIX_LL   = 5'd27;
  localparam logic [VAL_W-1:0] VAL_MIX_AL   = 5'd28;
  localparam logic [VAL_W-1:0] VAL_PUN_CHRS = 5'd29; // punct table size

  localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_LOWER_A = 8'h61;

  localparam logic [STATUS_W-1:0] ST_BYTE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  typedef enum logic [2:0] {
    MODE_ALPHA  = 3'd0,
    MODE_LOWER  = 3'd1,
    MODE_MIXED  = 3'd2,
    MODE_PUNCT  = 3'd3,
    MODE_ASHIFT = 3'd4,
    MODE_PSHIFT = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  mbs;   // sub-mode restored after a shift
  } dec_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic logic [BYTE_W-1:0] punct_char(input logic [VAL_W-1:0] v);
    logic [BYTE_W-1:0] c;
    unique case (v)
      5'd0:  c = 8'h3B;
      5'd1:  c = 8'h3C;
      5'd2:  c = 8'h3E;
      5'd3:  c = 8'h40;
      5'd4:  c = 8'h5B;
      5'd5:  c = 8'h5C;
      5'd6:  c = 8'h5D;
      5'd7:  c = 8'h5F;
      5'd8:  c = 8'h60;
      5'd9:  c = 8'h7E;
      5'd10: c = 8'h21;
      5'd11: c = 8'h0D;
      5'd12: c = 8'h09;
      5'd13: c = 8'h2C;
      5'd14: c = 8'h3A;
      5'd15: c = 8'h0A;
      5'd16: c = 8'h2D;
      5'd17: c = 8'h2E;
      5'd18: c = 8'h24;
      5'd19: c = 8'h2F;
      5'd20: c = 8'h22;
      5'd21: c = 8'h7C;
      5'd22: c = 8'h2A;
      5'd23: c = 8'h28;
      5'd24: c = 8'h29;
      5'd25: c = 8'h3F;
      5'd26: c = 8'h7B;
      5'd27: c = 8'h7D;
      5'd28: c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] mixed_char(input logic [VAL_W-1:0] v);
    logic [BYTE_W-1:0] c;
    unique case (v)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
        c = 8'h30 + {3'b000, v};
      5'd10: c = 8'h26;
      5'd11: c = 8'h0D;
      5'd12: c = 8'h09;
      5'd13: c = 8'h2C;
      5'd14: c = 8'h3A;
      5'd15: c = 8'h23;
      5'd16: c = 8'h2D;
      5'd17: c = 8'h2E;
      5'd18: c = 8'h24;
      5'd19: c = 8'h2F;
      5'd20: c = 8'h2B;
      5'd21: c = 8'h25;
      5'd22: c = 8'h2A;
      5'd23: c = 8'h3D;
      5'd24: c = 8'h5E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_terminator(input logic [CW_W-1:0] cw);
    return (cw == CW_TEXT_LATCH) || (cw == CW_BYTE_LATCH) || (cw == CW_NUM_LATCH) ||
           (cw == CW_MACRO_CTRL) || (cw == CW_MACRO_OPT) || (cw == CW_BYTE_LATCH6) ||
           (cw == CW_MACRO_BEGIN);
  endfunction

endpackage

// ===== sv/pdf417tc_if.sv =====
// Valid/ready channel interfaces for codeword input and decoded result output.
interface pdf417tc_in_if import pdf417tc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CW_W-1:0] codeword;
  logic            segment_start;

  modport source (output valid, output codeword, output segment_start, input ready);
  modport sink   (input valid, input codeword, input segment_start, output ready);
endinterface

interface pdf417tc_out_if import pdf417tc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== sv/pdf417_text_compaction_decoder.sv =====
// Top level of the PDF417 text compaction decoder.
// The single output register drains one result per cycle while out_ch.ready is high.
// Throughput: one codeword per cycle if it yields at most one result and the output
// is not stalled; results are buffered, then registered in the output register.
// Reset: synchronous active-low rst_n returns to Alpha sub-mode and empties all buffers.
module pdf417_text_compaction_decoder import pdf417tc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pdf417tc_in_if.sink      in_ch,
  pdf417tc_out_if.source   out_ch
);

  logic      in_accept;
  logic      in_ready;
  logic      in_ready_w;
  res_pair_t pair;
  res_t      out_res;

  // an item enters when the result buffer has room for its results
  assign in_ready    = in_ready_w;
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  // classify the codeword, decode both base-30 values, update sub-mode state
  pdf417tc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .codeword      (in_ch.codeword),
    .segment_start (in_ch.segment_start),
    .res_o         (pair)
  );

  // hold up to two results and hand them out one item per cycle while the output is ready
  pdf417tc_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .pair_i      (pair),
    .out_ready   (out_ch.ready),
    .in_ready_o  (in_ready_w),
    .out_valid_o (out_ch.valid),
    .out_res_o   (out_res)
  );

  assign out_ch.out_byte = out_res.out_byte;
  assign out_ch.status   = out_res.status;
  assign out_ch.last     = out_res.last;

endmodule

// ===== sv/pdf417tc_val_dec.sv =====
// Decoder of one base-30 text value through the current sub-mode.
module pdf417tc_val_dec import pdf417tc_pkg::*; (
  input  dec_state_t        st_i,
  input  logic [VAL_W-1:0]  val_i,
  output dec_state_t        st_o,
  output logic [BYTE_W-1:0] char_o,
  output logic              ps_o
);

  mode_t restore_mode;
  logic  is_lower;

  assign restore_mode = mode_t'({1'b0, st_i.mbs});
  assign is_lower     = (st_i.mode == MODE_LOWER);

  always_comb begin
    st_o   = st_i;
    char_o = '0;
    ps_o   = 1'b0;
    unique case (st_i.mode)
      MODE_MIXED: begin
        if (val_i < VAL_MIX_CHRS) begin
          char_o = mixed_char(val_i);
        end else if (val_i == VAL_MIX_PL) begin
          st_o.mode = MODE_PUNCT;
        end else if (val_i == VAL_MIX_SP) begin
          char_o = CHR_SPACE;
        end else if (val_i == VAL_MIX_LL) begin
          st_o.mode = MODE_LOWER;
        end else if (val_i == VAL_MIX_AL) begin
          st_o.mode = MODE_ALPHA;
        end else begin
          st_o.mbs  = st_i.mode[1:0];
          st_o.mode = MODE_PSHIFT;
          ps_o      = 1'b1;
        end
      end
      MODE_PUNCT: begin
        if (val_i < VAL_PUN_CHRS) begin
          char_o = punct_char(val_i);
        end else begin
          st_o.mode = MODE_ALPHA;
        end
      end
      MODE_ASHIFT: begin
        st_o.mode = restore_mode;
        if (val_i < VAL_LETTERS) begin
          char_o = CHR_UPPER_A + {3'b000, val_i};
        end else if (val_i == VAL_SPACE) begin
          char_o = CHR_SPACE;
        end
      end
      MODE_PSHIFT: begin
        if (val_i < VAL_PUN_CHRS) begin
          st_o.mode = restore_mode;
          char_o    = punct_char(val_i);
        end else begin
          st_o.mode = MODE_ALPHA;
        end
      end
      default: begin
        // Alpha, Lower, and the unused codes that act as Alpha
        if (!is_lower) st_o.mode = MODE_ALPHA;
        if (val_i < VAL_LETTERS) begin
          char_o = (is_lower ? CHR_LOWER_A : CHR_UPPER_A) + {3'b000, val_i};
        end else if (val_i == VAL_SPACE) begin
          char_o = CHR_SPACE;
        end else if (val_i == VAL_LL_AS) begin
          if (!is_lower) begin
            st_o.mode = MODE_LOWER;
          end else begin
            st_o.mbs  = MODE_LOWER[1:0];
            st_o.mode = MODE_ASHIFT;
          end
        end else if (val_i == VAL_ML) begin
          st_o.mode = MODE_MIXED;
        end else begin
          st_o.mbs  = is_lower ? MODE_LOWER[1:0] : MODE_ALPHA[1:0];
          st_o.mode = MODE_PSHIFT;
          ps_o      = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== sv/pdf417tc_ctrl.sv =====
// Codeword classifier and decoder state, producing up to two results per codeword.
module pdf417tc_ctrl import pdf417tc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic [CW_W-1:0] codeword,
  input  logic            segment_start,
  output res_pair_t       res_o
);

  dec_state_t st_r, st_nxt;
  logic       psf_r, psf_nxt;
  logic       raw_r, raw_nxt;
  logic [1:0] skip_r, skip_nxt;

  dec_state_t eff_st;
  logic       eff_psf, eff_raw;
  logic [1:0] eff_skip;

  logic [PROD_W-1:0] prod;
  logic [5:0]        quot;
  logic [CW_W:0]     quot30;
  logic [CW_W:0]     rem;
  logic [VAL_W-1:0]  val_hi, val_lo;

  dec_state_t        st_mid, st_end;
  logic [BYTE_W-1:0] chr0, chr1;
  logic              ps0, ps1;
  logic              is_eci;

  // segment start clears the state before this codeword is handled
  always_comb begin
    if (segment_start) begin
      eff_st   = '{mode: MODE_ALPHA, mbs: MODE_ALPHA[1:0]};
      eff_psf  = 1'b0;
      eff_raw  = 1'b0;
      eff_skip = '0;
    end else begin
      eff_st   = st_r;
      eff_psf  = psf_r;
      eff_raw  = raw_r;
      eff_skip = skip_r;
    end
  end

  // split into two base-30 values by reciprocal multiply
  assign prod   = PROD_W'(codeword) * PROD_W'(DIV30_MUL);
  assign quot   = prod[PROD_W-1:DIV30_SHIFT];
  assign quot30 = ({5'b00000, quot} << 5) - ({5'b00000, quot} << 1);
  assign rem    = {1'b0, codeword} - quot30;
  assign val_hi = quot[VAL_W-1:0];
  assign val_lo = rem[VAL_W-1:0];

  pdf417tc_val_dec u_dec_hi (
    .st_i   (eff_st),
    .val_i  (val_hi),
    .st_o   (st_mid),
    .char_o (chr0),
    .ps_o   (ps0)
  );

  pdf417tc_val_dec u_dec_lo (
    .st_i   (st_mid),
    .val_i  (val_lo),
    .st_o   (st_end),
    .char_o (chr1),
    .ps_o   (ps1)
  );

  assign is_eci = (codeword == CW_ECI_USER) || (codeword == CW_ECI_GP) ||
                  (codeword == CW_ECI_CHARSET);

  always_comb begin
    st_nxt   = eff_st;
    psf_nxt  = eff_psf;
    raw_nxt  = eff_raw;
    skip_nxt = eff_skip;
    res_o    = '0;
    priority if (eff_skip != 2'd0) begin
      skip_nxt = eff_skip - 2'd1;
      psf_nxt  = 1'b0;
    end else if (is_eci) begin
      skip_nxt = (codeword == CW_ECI_GP) ? 2'd2 : 2'd1;
      psf_nxt  = 1'b0;
    end else if (eff_raw) begin
      raw_nxt  = 1'b0;
      psf_nxt  = 1'b0;
      res_o.cnt = 2'd1;
      res_o.r0  = '{out_byte: codeword[BYTE_W-1:0], status: ST_BYTE, last: 1'b1};
    end else if (codeword == CW_BYTE_SHIFT) begin
      // cancel a punct shift taken just before the byte shift
      if (eff_psf) st_nxt.mode = mode_t'({1'b0, eff_st.mbs});
      psf_nxt = 1'b0;
      raw_nxt = 1'b1;
    end else if (codeword < CW_FIRST_CTRL) begin
      st_nxt  = st_end;
      psf_nxt = ps1;
      if (chr0 != '0 && chr1 != '0) begin
        res_o.cnt = 2'd2;
        res_o.r0  = '{out_byte: chr0, status: ST_BYTE, last: 1'b0};
        res_o.r1  = '{out_byte: chr1, status: ST_BYTE, last: 1'b1};
      end else if (chr0 != '0) begin
        res_o.cnt = 2'd1;
        res_o.r0  = '{out_byte: chr0, status: ST_BYTE, last: 1'b1};
      end else if (chr1 != '0) begin
        res_o.cnt = 2'd1;
        res_o.r0  = '{out_byte: chr1, status: ST_BYTE, last: 1'b1};
      end
    end else begin
      st_nxt   = '{mode: MODE_ALPHA, mbs: MODE_ALPHA[1:0]};
      psf_nxt  = 1'b0;
      raw_nxt  = 1'b0;
      skip_nxt = '0;
      res_o.cnt = 2'd1;
      res_o.r0  = '{out_byte: '0, status: is_terminator(codeword) ? ST_END : ST_ERROR,
                    last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '{mode: MODE_ALPHA, mbs: MODE_ALPHA[1:0]};
      psf_r  <= 1'b0;
      raw_r  <= 1'b0;
      skip_r <= '0;
    end else if (in_accept) begin
      st_r   <= st_nxt;
      psf_r  <= psf_nxt;
      raw_r  <= raw_nxt;
      skip_r <= skip_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r != 2'd3)
    else $error("ECI skip count out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && res_o.cnt != 2'd0 && res_o.r0.status != ST_BYTE |=>
      st_r.mode == MODE_ALPHA && !raw_r && !psf_r && skip_r == 2'd0)
    else $error("segment end or error did not clear decoder state");
`endif

endmodule

// ===== sv/pdf417tc_out_buf.sv =====
// Two-entry result buffer and output register that serialize results one per ready cycle.
module pdf417tc_out_buf import pdf417tc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_accept,
  input  res_pair_t pair_i,
  input  logic      out_ready,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output res_t      out_res_o
);

  res_t       pair_r [2];
  logic [1:0] pair_cnt_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       out_load;

  assign out_load   = (pair_cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign in_ready_o = (pair_cnt_r == 2'd0) || ((pair_cnt_r == 2'd1) && out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        pair_cnt_r <= pair_i.cnt;
      end else if (out_load) begin
        pair_cnt_r <= pair_cnt_r - 2'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pair_r[0] <= pair_i.r0;
      pair_r[1] <= pair_i.r1;
    end else if (out_load) begin
      pair_r[0] <= pair_r[1];
    end
    if (out_load) out_res_r <= pair_r[0];
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pair_cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pair_cnt_r == 2'd2 |-> !in_ready_o && !pair_r[0].last)
    else $error("full result buffer accepted input or holds a misplaced last");

  a_nonlast_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.last |-> out_res_r.status == ST_BYTE)
    else $error("non-final result carries a status code");
`endif

endmodule
